>>> rtl/tga_pkg.sv
`timescale 1ns / 1ps

package tga_pkg;

    localparam int HEADER_LEN      = 18;
    localparam int FOOTER_LEN      = 26;
    localparam int SIG_START       = 8;
    localparam int SIG_LEN         = 17;
    localparam int TRAILER_SAT     = 27;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] DEPTH_24  = 8'd24;
    localparam logic [7:0] DEPTH_32  = 8'd32;
    localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;
    localparam int         DESC_FLIP_X_BIT = 4;
    localparam int         DESC_TOP_BIT    = 5;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_SHORT_HEADER = 2'd1;
    localparam logic [1:0] ST_BAD_FORMAT   = 2'd2;
    localparam logic [1:0] ST_SIZE_MISMATCH = 2'd3;

    localparam logic [4:0] HDR_ID_LEN     = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE   = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_BPP        = 5'd16;
    localparam logic [4:0] HDR_DESC       = 5'd17;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_PIXELS,
        PH_TRAILER,
        PH_REJECT
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [1:0]  status;
        logic        end_of_run;
    } out_item_t;

    typedef struct packed {
        logic        has_pixel;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        has_status;
        logic [1:0]  status;
    } event_t;

    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h54;
            5'd1:    b = 8'h52;
            5'd2:    b = 8'h55;
            5'd3:    b = 8'h45;
            5'd4:    b = 8'h56;
            5'd5:    b = 8'h49;
            5'd6:    b = 8'h53;
            5'd7:    b = 8'h49;
            5'd8:    b = 8'h4f;
            5'd9:    b = 8'h4e;
            5'd10:   b = 8'h2d;
            5'd11:   b = 8'h58;
            5'd12:   b = 8'h46;
            5'd13:   b = 8'h49;
            5'd14:   b = 8'h4c;
            5'd15:   b = 8'h45;
            5'd16:   b = 8'h2e;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/tga_truecolor_stream_decoder_unit.sv
`timescale 1ns / 1ps
// channel   | role   | handshake                   | payload
// ----------+--------+-----------------------------+---------------------------
// byte      | input  | byte_valid / byte_ready     | byte_item   (in_item_t)
// result    | output | result_valid / result_ready | result_item (out_item_t)
//
// one file byte accepted per cycle while the request queue has room
// a result is registered in the output stage after its request has passed through the queue
// a byte giving both a pixel and the status yields two results, the pixel first, then the status
// the queue of QUEUE_DEPTH requests absorbs output stalls
// rst_n async clear; no clearing pass, byte_ready already high when reset releases

module tga_truecolor_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tga_pkg::in_item_t  byte_item,
    output logic               result_valid,
    input  logic               result_ready,
    output tga_pkg::out_item_t result_item
);
    import tga_pkg::*;

    event_t push_ev;
    event_t head_ev;
    logic   push;
    logic   space;
    logic   pop;
    logic   head_valid;

    tga_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .space      (space),
        .push       (push),
        .ev         (push_ev)
    );

    tga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ev    (push_ev),
        .space      (space),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ev    (head_ev)
    );

    tga_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_ev      (head_ev),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

>>> rtl/tga_front.sv
`timescale 1ns / 1ps

module tga_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  tga_pkg::in_item_t byte_item,
    input  logic              space,
    output logic              push,
    output tga_pkg::event_t   ev
);
    import tga_pkg::*;

    logic [4:0]  header_index_reg, header_index_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  id_remaining_reg, id_remaining_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic        four_byte_reg, four_byte_next;
    logic        flip_x_reg, flip_x_next;
    logic        top_origin_reg, top_origin_next;
    logic        format_bad_reg, format_bad_next;
    logic [15:0] column_reg, column_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [4:0]  trailer_count_reg, trailer_count_next;
    logic        footer_match_reg, footer_match_next;

    logic        accept;
    logic [7:0]  d;
    logic [1:0]  last_lane;
    logic [16:0] column_inc;
    logic [16:0] row_inc;

    assign byte_ready = space;
    assign accept     = byte_valid && byte_ready;
    assign d          = byte_item.data_byte;
    assign last_lane  = four_byte_reg ? 2'd3 : 2'd2;
    assign column_inc = {1'b0, column_reg} + 17'd1;
    assign row_inc    = {1'b0, row_reg} + 17'd1;

    always_comb
    begin
        header_index_next  = header_index_reg;
        phase_next         = phase_reg;
        id_remaining_next  = id_remaining_reg;
        image_width_next   = image_width_reg;
        image_height_next  = image_height_reg;
        four_byte_next     = four_byte_reg;
        flip_x_next        = flip_x_reg;
        top_origin_next    = top_origin_reg;
        format_bad_next    = format_bad_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        trailer_count_next = trailer_count_reg;
        footer_match_next  = footer_match_reg;
        ev                 = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (header_index_reg)
                        HDR_ID_LEN:    id_remaining_next = d;
                        HDR_CMAP_TYPE: if (d != 8'd0) format_bad_next = 1'b1;
                        HDR_IMG_TYPE:  if (d != IMG_TRUECOLOR) format_bad_next = 1'b1;
                        HDR_WIDTH_LO:  image_width_next = {8'd0, d};
                        HDR_WIDTH_HI:  image_width_next = {d, image_width_reg[7:0]};
                        HDR_HEIGHT_LO: image_height_next = {8'd0, d};
                        HDR_HEIGHT_HI: image_height_next = {d, image_height_reg[7:0]};
                        HDR_BPP:
                        begin
                            priority if (d == DEPTH_32) four_byte_next = 1'b1;
                            else if (d == DEPTH_24) four_byte_next = 1'b0;
                            else format_bad_next = 1'b1;
                        end
                        HDR_DESC:
                        begin
                            flip_x_next     = d[DESC_FLIP_X_BIT];
                            top_origin_next = d[DESC_TOP_BIT];
                            if (image_width_reg == 16'd0 || image_height_reg == 16'd0)
                                format_bad_next = 1'b1;
                        end
                        default: ;
                    endcase
                    if (header_index_reg == 5'(HEADER_LEN - 1))
                    begin
                        header_index_next = 5'd0;
                        priority if (format_bad_next) phase_next = PH_REJECT;
                        else if (id_remaining_reg != 8'd0) phase_next = PH_ID;
                        else phase_next = PH_PIXELS;
                    end
                    else
                    begin
                        header_index_next = header_index_reg + 5'd1;
                    end
                end
                PH_ID:
                begin
                    id_remaining_next = id_remaining_reg - 8'd1;
                    if (id_remaining_next == 8'd0) phase_next = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    if (byte_in_pixel_reg < last_lane)
                    begin
                        unique case (byte_in_pixel_reg)
                            2'd0:    pixel_bytes_next[7:0]   = d;
                            2'd1:    pixel_bytes_next[15:8]  = d;
                            2'd2:    pixel_bytes_next[23:16] = d;
                            default: ;
                        endcase
                        byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                    end
                    else
                    begin
                        ev.has_pixel = 1'b1;
                        ev.blue      = pixel_bytes_reg[7:0];
                        ev.green     = pixel_bytes_reg[15:8];
                        ev.red       = four_byte_reg ? pixel_bytes_reg[23:16] : d;
                        ev.alpha     = four_byte_reg ? d : ALPHA_OPAQUE;
                        ev.dest_x    = flip_x_reg ? image_width_reg - 16'd1 - column_reg
                                                  : column_reg;
                        ev.dest_y    = top_origin_reg ? row_reg
                                                      : image_height_reg - 16'd1 - row_reg;
                        byte_in_pixel_next = 2'd0;
                        pixel_bytes_next   = '0;
                        if (column_inc >= {1'b0, image_width_reg})
                        begin
                            column_next = 16'd0;
                            if (row_inc >= {1'b0, image_height_reg})
                            begin
                                row_next   = 16'd0;
                                phase_next = PH_TRAILER;
                            end
                            else
                            begin
                                row_next = row_inc[15:0];
                            end
                        end
                        else
                        begin
                            column_next = column_inc[15:0];
                        end
                    end
                end
                PH_TRAILER:
                begin
                    if (trailer_count_reg >= 5'(SIG_START) &&
                        trailer_count_reg < 5'(SIG_START + SIG_LEN))
                    begin
                        if (d != sig_byte(trailer_count_reg - 5'(SIG_START)))
                            footer_match_next = 1'b0;
                    end
                    if (trailer_count_reg < 5'(TRAILER_SAT))
                        trailer_count_next = trailer_count_reg + 5'd1;
                end
                PH_REJECT: ;
                default: ;
            endcase

            if (byte_item.last_byte)
            begin
                ev.has_status = 1'b1;
                unique case (phase_next)
                    PH_HEADER: ev.status = ST_SHORT_HEADER;
                    PH_REJECT: ev.status = ST_BAD_FORMAT;
                    PH_TRAILER:
                    begin
                        if (trailer_count_next == 5'd0 ||
                            (trailer_count_next == 5'(FOOTER_LEN) && footer_match_next))
                            ev.status = ST_OK;
                        else
                            ev.status = ST_SIZE_MISMATCH;
                    end
                    default: ev.status = ST_SIZE_MISMATCH;
                endcase
                header_index_next  = 5'd0;
                phase_next         = PH_HEADER;
                id_remaining_next  = 8'd0;
                image_width_next   = 16'd0;
                image_height_next  = 16'd0;
                four_byte_next     = 1'b0;
                flip_x_next        = 1'b0;
                top_origin_next    = 1'b0;
                format_bad_next    = 1'b0;
                column_next        = 16'd0;
                row_next           = 16'd0;
                byte_in_pixel_next = 2'd0;
                pixel_bytes_next   = '0;
                trailer_count_next = 5'd0;
                footer_match_next  = 1'b1;
            end
        end
    end

    assign push = accept && (ev.has_pixel || ev.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg  <= 5'd0;
            phase_reg         <= PH_HEADER;
            id_remaining_reg  <= 8'd0;
            image_width_reg   <= 16'd0;
            image_height_reg  <= 16'd0;
            four_byte_reg     <= 1'b0;
            flip_x_reg        <= 1'b0;
            top_origin_reg    <= 1'b0;
            format_bad_reg    <= 1'b0;
            column_reg        <= 16'd0;
            row_reg           <= 16'd0;
            byte_in_pixel_reg <= 2'd0;
            pixel_bytes_reg   <= '0;
            trailer_count_reg <= 5'd0;
            footer_match_reg  <= 1'b1;
        end
        else
        begin
            header_index_reg  <= header_index_next;
            phase_reg         <= phase_next;
            id_remaining_reg  <= id_remaining_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            four_byte_reg     <= four_byte_next;
            flip_x_reg        <= flip_x_next;
            top_origin_reg    <= top_origin_next;
            format_bad_reg    <= format_bad_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            pixel_bytes_reg   <= pixel_bytes_next;
            trailer_count_reg <= trailer_count_next;
            footer_match_reg  <= footer_match_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_item.last_byte |=> phase_reg == PH_HEADER && header_index_reg == 5'd0)
        else $error("last byte did not return parser to header");
    a_trailer_sat: assert property (@(posedge clk) disable iff (!rst_n)
        trailer_count_reg <= 5'(TRAILER_SAT))
        else $error("trailer count beyond saturation");
`endif

endmodule

>>> rtl/tga_queue.sv
`timescale 1ns / 1ps

module tga_queue #(
    parameter int DEPTH = tga_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tga_pkg::event_t push_ev,
    output logic            space,
    input  logic            pop,
    output logic            head_valid,
    output tga_pkg::event_t head_ev
);
    import tga_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    event_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign space      = count_reg != CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_ev    = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |-> space)
        else $error("push into full queue");
`endif

endmodule

>>> rtl/tga_back.sv
`timescale 1ns / 1ps

module tga_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  tga_pkg::event_t    head_ev,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_ready,
    output tga_pkg::out_item_t result_item
);
    import tga_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic      pix_done_reg, pix_done_next;
    logic      load;

    assign load         = head_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    always_comb
    begin
        out_next       = out_reg;
        pix_done_next  = pix_done_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_next       = '0;
            if (head_ev.has_pixel && !pix_done_reg)
            begin
                out_next.kind   = KIND_PIXEL;
                out_next.dest_x = head_ev.dest_x;
                out_next.dest_y = head_ev.dest_y;
                out_next.red    = head_ev.red;
                out_next.green  = head_ev.green;
                out_next.blue   = head_ev.blue;
                out_next.alpha  = head_ev.alpha;
                out_next.status = ST_OK;
                if (head_ev.has_status)
                    pix_done_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                out_next.kind       = KIND_STATUS;
                out_next.status     = head_ev.status;
                out_next.end_of_run = 1'b1;
                pix_done_next       = 1'b0;
                pop                 = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pix_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pix_done_reg  <= pix_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_split_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pix_done_reg |-> head_valid && head_ev.has_status && head_ev.has_pixel)
        else $error("split request without pending status");
    a_status_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load && pix_done_reg |=> out_reg.kind == KIND_STATUS && out_reg.end_of_run)
        else $error("status did not follow final pixel");
`endif

endmodule
